// ----- hdl/hrot_pkg.sv -----
// Shared constants and product/term index names for the Hermitian 2x2 rotation pipeline.
`default_nettype none

package hrot_pkg;

    // Matrix word width at the default build (Q15.16).
    localparam int DATA_WIDTH_DEF = 32;

    // Rotation words are Q1.30 in a fixed 32-bit field.
    localparam int ROT_W    = 32;
    localparam int ROT_FRAC = 30;

    // First product bank: matrix element times rotation component.
    localparam int N_PROD   = 12;
    localparam int P_C_ZR   = 0;
    localparam int P_SR_X   = 1;
    localparam int P_C_ZI   = 2;
    localparam int P_SI_X   = 3;
    localparam int P_SR_Y   = 4;
    localparam int P_SI_Y   = 5;
    localparam int P_C_X    = 6;
    localparam int P_SR_ZR  = 7;
    localparam int P_SI_ZI  = 8;
    localparam int P_C_Y    = 9;
    localparam int P_SR_ZI  = 10;
    localparam int P_SI_ZR  = 11;

    // Intermediate terms of the left-hand rotation.
    localparam int N_TERM   = 7;
    localparam int T_T3R    = 0;
    localparam int T_T3I    = 1;
    localparam int T_T4R    = 2;
    localparam int T_T4I    = 3;
    localparam int T_T5     = 4;
    localparam int T_T6     = 5;
    localparam int T_T1I    = 6;

    // Second product bank: intermediate term times rotation component.
    localparam int N_QPROD  = 12;
    localparam int Q_C_T5   = 0;
    localparam int Q_SR_T4R = 1;
    localparam int Q_SI_T4I = 2;
    localparam int Q_C_T6   = 3;
    localparam int Q_SR_T3R = 4;
    localparam int Q_SI_T3I = 5;
    localparam int Q_C_T3R  = 6;
    localparam int Q_SR_T6  = 7;
    localparam int Q_SI_T1I = 8;
    localparam int Q_C_T3I  = 9;
    localparam int Q_SR_T1I = 10;
    localparam int Q_SI_T6  = 11;

endpackage

`default_nettype wire

// ----- hdl/hrot_mul_in.sv -----
// First pipeline stage: the twelve matrix-by-rotation products, registered.
`default_nettype none

module hrot_mul_in
    import hrot_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int PW = DATA_WIDTH + ROT_W
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic signed [DATA_WIDTH-1:0] i_x,
    input  wire logic signed [DATA_WIDTH-1:0] i_y,
    input  wire logic signed [DATA_WIDTH-1:0] i_zr,
    input  wire logic signed [DATA_WIDTH-1:0] i_zi,
    input  wire logic signed [ROT_W-1:0]      i_c,
    input  wire logic signed [ROT_W-1:0]      i_sr,
    input  wire logic signed [ROT_W-1:0]      i_si,
    output logic signed [PW-1:0]              o_prod [N_PROD],
    output logic signed [ROT_W-1:0]           o_c,
    output logic signed [ROT_W-1:0]           o_sr,
    output logic signed [ROT_W-1:0]           o_si
);

    logic signed [PW-1:0]    r_prod [N_PROD];
    logic signed [ROT_W-1:0] r_c;
    logic signed [ROT_W-1:0] r_sr;
    logic signed [ROT_W-1:0] r_si;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod[P_C_ZR]  <= PW'(i_c)  * PW'(i_zr);
            r_prod[P_SR_X]  <= PW'(i_sr) * PW'(i_x);
            r_prod[P_C_ZI]  <= PW'(i_c)  * PW'(i_zi);
            r_prod[P_SI_X]  <= PW'(i_si) * PW'(i_x);
            r_prod[P_SR_Y]  <= PW'(i_sr) * PW'(i_y);
            r_prod[P_SI_Y]  <= PW'(i_si) * PW'(i_y);
            r_prod[P_C_X]   <= PW'(i_c)  * PW'(i_x);
            r_prod[P_SR_ZR] <= PW'(i_sr) * PW'(i_zr);
            r_prod[P_SI_ZI] <= PW'(i_si) * PW'(i_zi);
            r_prod[P_C_Y]   <= PW'(i_c)  * PW'(i_y);
            r_prod[P_SR_ZI] <= PW'(i_sr) * PW'(i_zi);
            r_prod[P_SI_ZR] <= PW'(i_si) * PW'(i_zr);
            r_c             <= i_c;
            r_sr            <= i_sr;
            r_si            <= i_si;
        end
    end

    assign o_prod = r_prod;
    assign o_c    = r_c;
    assign o_sr   = r_sr;
    assign o_si   = r_si;

endmodule

`default_nettype wire

// ----- hdl/hrot_sum_mid.sv -----
// Second pipeline stage: sums of the first products, rounded to the intermediate terms.
`default_nettype none

module hrot_sum_mid
    import hrot_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int PW = DATA_WIDTH + ROT_W,
    localparam int TW = DATA_WIDTH + 4
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [PW-1:0]    i_prod [N_PROD],
    input  wire logic signed [ROT_W-1:0] i_c,
    input  wire logic signed [ROT_W-1:0] i_sr,
    input  wire logic signed [ROT_W-1:0] i_si,
    output logic signed [TW-1:0]         o_term [N_TERM],
    output logic signed [ROT_W-1:0]      o_c,
    output logic signed [ROT_W-1:0]      o_sr,
    output logic signed [ROT_W-1:0]      o_si
);

    // Two guard bits cover a sum of three products.
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] HALF =
        {{(SW - ROT_FRAC){1'b0}}, 1'b1, {(ROT_FRAC - 1){1'b0}}};

    function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] v);
        return {{(SW - PW){v[PW-1]}}, v};
    endfunction

    // Round half upwards, then drop the rotation fraction bits.
    function automatic logic signed [TW-1:0] rnd(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = v + HALF;
        return r[SW-1:ROT_FRAC];
    endfunction

    logic signed [TW-1:0]    n_term [N_TERM];
    logic signed [TW-1:0]    r_term [N_TERM];
    logic signed [ROT_W-1:0] r_c;
    logic signed [ROT_W-1:0] r_sr;
    logic signed [ROT_W-1:0] r_si;

    always_comb begin
        n_term[T_T3R] = rnd(ext(i_prod[P_C_ZR]) - ext(i_prod[P_SR_X]));
        n_term[T_T3I] = rnd(ext(i_prod[P_C_ZI]) + ext(i_prod[P_SI_X]));
        n_term[T_T4R] = rnd(ext(i_prod[P_C_ZR]) + ext(i_prod[P_SR_Y]));
        n_term[T_T4I] = rnd(ext(i_prod[P_SI_Y]) - ext(i_prod[P_C_ZI]));
        n_term[T_T5]  = rnd(ext(i_prod[P_C_X]) + ext(i_prod[P_SR_ZR])
                            - ext(i_prod[P_SI_ZI]));
        n_term[T_T6]  = rnd(ext(i_prod[P_C_Y]) - ext(i_prod[P_SR_ZR])
                            + ext(i_prod[P_SI_ZI]));
        n_term[T_T1I] = rnd(ext(i_prod[P_SR_ZI]) + ext(i_prod[P_SI_ZR]));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= n_term;
            r_c    <= i_c;
            r_sr   <= i_sr;
            r_si   <= i_si;
        end
    end

    assign o_term = r_term;
    assign o_c    = r_c;
    assign o_sr   = r_sr;
    assign o_si   = r_si;

endmodule

`default_nettype wire

// ----- hdl/hrot_mul_mid.sv -----
// Third pipeline stage: the twelve term-by-rotation products, registered.
`default_nettype none

module hrot_mul_mid
    import hrot_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int TW = DATA_WIDTH + 4,
    localparam int QW = TW + ROT_W
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [TW-1:0]    i_term [N_TERM],
    input  wire logic signed [ROT_W-1:0] i_c,
    input  wire logic signed [ROT_W-1:0] i_sr,
    input  wire logic signed [ROT_W-1:0] i_si,
    output logic signed [QW-1:0]         o_qprod [N_QPROD]
);

    logic signed [QW-1:0] r_qprod [N_QPROD];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qprod[Q_C_T5]   <= QW'(i_c)  * QW'(i_term[T_T5]);
            r_qprod[Q_SR_T4R] <= QW'(i_sr) * QW'(i_term[T_T4R]);
            r_qprod[Q_SI_T4I] <= QW'(i_si) * QW'(i_term[T_T4I]);
            r_qprod[Q_C_T6]   <= QW'(i_c)  * QW'(i_term[T_T6]);
            r_qprod[Q_SR_T3R] <= QW'(i_sr) * QW'(i_term[T_T3R]);
            r_qprod[Q_SI_T3I] <= QW'(i_si) * QW'(i_term[T_T3I]);
            r_qprod[Q_C_T3R]  <= QW'(i_c)  * QW'(i_term[T_T3R]);
            r_qprod[Q_SR_T6]  <= QW'(i_sr) * QW'(i_term[T_T6]);
            r_qprod[Q_SI_T1I] <= QW'(i_si) * QW'(i_term[T_T1I]);
            r_qprod[Q_C_T3I]  <= QW'(i_c)  * QW'(i_term[T_T3I]);
            r_qprod[Q_SR_T1I] <= QW'(i_sr) * QW'(i_term[T_T1I]);
            r_qprod[Q_SI_T6]  <= QW'(i_si) * QW'(i_term[T_T6]);
        end
    end

    assign o_qprod = r_qprod;

endmodule

`default_nettype wire

// ----- hdl/hrot_sum_out.sv -----
// Fourth pipeline stage: final sums, rounding and saturation into the output register.
`default_nettype none

module hrot_sum_out
    import hrot_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int TW = DATA_WIDTH + 4,
    localparam int QW = TW + ROT_W
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic signed [QW-1:0]         i_qprod [N_QPROD],
    output logic signed [DATA_WIDTH-1:0]      o_x,
    output logic signed [DATA_WIDTH-1:0]      o_y,
    output logic signed [DATA_WIDTH-1:0]      o_zr,
    output logic signed [DATA_WIDTH-1:0]      o_zi
);

    localparam int SW = QW + 2;
    localparam int RW = SW - ROT_FRAC;
    localparam logic signed [SW-1:0] HALF =
        {{(SW - ROT_FRAC){1'b0}}, 1'b1, {(ROT_FRAC - 1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    function automatic logic signed [SW-1:0] ext(input logic signed [QW-1:0] v);
        return {{(SW - QW){v[QW-1]}}, v};
    endfunction

    // Round half upwards, then clamp to the matrix word range.
    function automatic logic signed [DATA_WIDTH-1:0] rnd_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        logic signed [RW-1:0] q;
        logic                 fits;
        r    = v + HALF;
        q    = r[SW-1:ROT_FRAC];
        fits = (&q[RW-1:DATA_WIDTH-1]) || !(|q[RW-1:DATA_WIDTH-1]);
        if (fits) begin
            return q[DATA_WIDTH-1:0];
        end else if (q[RW-1]) begin
            return MINV;
        end else begin
            return MAXV;
        end
    endfunction

    logic signed [DATA_WIDTH-1:0] n_x, n_y, n_zr, n_zi;
    logic signed [DATA_WIDTH-1:0] r_x, r_y, r_zr, r_zi;

    always_comb begin
        n_x  = rnd_sat(ext(i_qprod[Q_C_T5]) + ext(i_qprod[Q_SR_T4R])
                       + ext(i_qprod[Q_SI_T4I]));
        n_y  = rnd_sat(ext(i_qprod[Q_C_T6]) - ext(i_qprod[Q_SR_T3R])
                       + ext(i_qprod[Q_SI_T3I]));
        n_zr = rnd_sat(ext(i_qprod[Q_C_T3R]) + ext(i_qprod[Q_SR_T6])
                       + ext(i_qprod[Q_SI_T1I]));
        n_zi = rnd_sat(ext(i_qprod[Q_C_T3I]) + ext(i_qprod[Q_SR_T1I])
                       - ext(i_qprod[Q_SI_T6]));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_zr <= n_zr;
            r_zi <= n_zi;
        end
    end

    assign o_x  = r_x;
    assign o_y  = r_y;
    assign o_zr = r_zr;
    assign o_zi = r_zi;

endmodule

`default_nettype wire

// ----- hdl/hermitian_2x2_complex_rotation.sv -----
// Top level of the two-sided complex rotation of a Hermitian 2x2 matrix.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       i_in_valid / o_in_stall    diag_x, diag_y, offdiag_re/im,
//                                                  cosine, sine_re/im, last_in
//   out      source     o_out_valid / i_out_stall  new_x, new_y, new_z_re/im, last_out
//
// An item occupies four stages. The edge that accepts it loads stage one; from there it
// moves through stages two and three into stage four, whose register drives the output.
// One item can be accepted on every cycle while o_in_stall is low; the four-stage
// pipeline holds two multiplier banks and two adder/rounding stages.
// Reset is synchronous and active low; it clears only the stage valid bits.
// The stage enables are chained combinationally: a stage loads when it is empty or
// when the stage after it moves on, so bubbles inside the pipe are filled even while
// the output waits, and o_in_stall rises only when all four stages hold an item and
// the output is stalled.
`default_nettype none

module hermitian_2x2_complex_rotation
    import hrot_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Input channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic signed [DATA_WIDTH-1:0] i_diag_x,
    input  wire logic signed [DATA_WIDTH-1:0] i_diag_y,
    input  wire logic signed [DATA_WIDTH-1:0] i_offdiag_re,
    input  wire logic signed [DATA_WIDTH-1:0] i_offdiag_im,
    input  wire logic signed [ROT_W-1:0]      i_cosine,
    input  wire logic signed [ROT_W-1:0]      i_sine_re,
    input  wire logic signed [ROT_W-1:0]      i_sine_im,
    input  wire logic                         i_last_in,
    // Output channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0]      o_new_x,
    output logic signed [DATA_WIDTH-1:0]      o_new_y,
    output logic signed [DATA_WIDTH-1:0]      o_new_z_re,
    output logic signed [DATA_WIDTH-1:0]      o_new_z_im,
    output logic                              o_last_out
);

    localparam int PW = DATA_WIDTH + ROT_W;
    localparam int TW = DATA_WIDTH + 4;
    localparam int QW = TW + ROT_W;

    // Stage valid bits and the last flag that travels beside each item.
    logic r_v_s1, r_v_s2, r_v_s3, r_v_s4;
    logic r_last_s1, r_last_s2, r_last_s3, r_last_s4;

    // A stage loads when it is empty or when the stage after it loads too.
    logic en_s1, en_s2, en_s3, en_s4;

    logic signed [PW-1:0]    prod [N_PROD];
    logic signed [ROT_W-1:0] c_s1, sr_s1, si_s1;
    logic signed [TW-1:0]    term [N_TERM];
    logic signed [ROT_W-1:0] c_s2, sr_s2, si_s2;
    logic signed [QW-1:0]    qprod [N_QPROD];

    assign en_s4 = !r_v_s4 || !i_out_stall;
    assign en_s3 = !r_v_s3 || en_s4;
    assign en_s2 = !r_v_s2 || en_s3;
    assign en_s1 = !r_v_s1 || en_s2;

    assign o_in_stall = !en_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_s1 <= 1'b0;
            r_v_s2 <= 1'b0;
            r_v_s3 <= 1'b0;
            r_v_s4 <= 1'b0;
        end else begin
            if (en_s1) begin
                r_v_s1 <= i_in_valid;
            end
            if (en_s2) begin
                r_v_s2 <= r_v_s1;
            end
            if (en_s3) begin
                r_v_s3 <= r_v_s2;
            end
            if (en_s4) begin
                r_v_s4 <= r_v_s3;
            end
        end
    end

    // The last flag is payload and needs no reset.
    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_last_s1 <= i_last_in;
        end
        if (en_s2) begin
            r_last_s2 <= r_last_s1;
        end
        if (en_s3) begin
            r_last_s3 <= r_last_s2;
        end
        if (en_s4) begin
            r_last_s4 <= r_last_s3;
        end
    end

    // Stage one: every matrix element against every rotation component it meets.
    hrot_mul_in #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul_in (
        .i_clk  (i_clk),
        .i_en   (en_s1),
        .i_x    (i_diag_x),
        .i_y    (i_diag_y),
        .i_zr   (i_offdiag_re),
        .i_zi   (i_offdiag_im),
        .i_c    (i_cosine),
        .i_sr   (i_sine_re),
        .i_si   (i_sine_im),
        .o_prod (prod),
        .o_c    (c_s1),
        .o_sr   (sr_s1),
        .o_si   (si_s1)
    );

    // Stage two: the seven intermediate terms, rounded back to matrix scale.
    hrot_sum_mid #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_sum_mid (
        .i_clk  (i_clk),
        .i_en   (en_s2),
        .i_prod (prod),
        .i_c    (c_s1),
        .i_sr   (sr_s1),
        .i_si   (si_s1),
        .o_term (term),
        .o_c    (c_s2),
        .o_sr   (sr_s2),
        .o_si   (si_s2)
    );

    // Stage three: the right-hand rotation products.
    hrot_mul_mid #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mul_mid (
        .i_clk   (i_clk),
        .i_en    (en_s3),
        .i_term  (term),
        .i_c     (c_s2),
        .i_sr    (sr_s2),
        .i_si    (si_s2),
        .o_qprod (qprod)
    );

    // Stage four: final rounding and saturation; its register is the output register.
    hrot_sum_out #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_sum_out (
        .i_clk   (i_clk),
        .i_en    (en_s4),
        .i_qprod (qprod),
        .o_x     (o_new_x),
        .o_y     (o_new_y),
        .o_zr    (o_new_z_re),
        .o_zi    (o_new_z_im)
    );

    assign o_out_valid = r_v_s4;
    assign o_last_out  = r_last_s4;

endmodule

`default_nettype wire

// ----- hdl/hrot_checker.sv -----
// Port-level checks for the Hermitian rotation pipeline, bound to the top level.
`default_nettype none

module hrot_checker
    import hrot_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic signed [DATA_WIDTH-1:0] o_new_x,
    input wire logic signed [DATA_WIDTH-1:0] o_new_y,
    input wire logic signed [DATA_WIDTH-1:0] o_new_z_re,
    input wire logic signed [DATA_WIDTH-1:0] o_new_z_im,
    input wire logic                         o_last_out
);

    // A result held under stall stays valid and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_new_x) && $stable(o_new_y) &&
            $stable(o_new_z_re) && $stable(o_new_z_im) && $stable(o_last_out))
        else $error("output item changed while stalled");

    // With no result waiting, the pipe cannot be full, so input is never stalled.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output is empty");

    // An accepted item reaches the output when the output is not stalled while it passes through.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall ##1 !i_out_stall
            ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted item did not reach the output in time");

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind hermitian_2x2_complex_rotation hrot_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_hrot_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_new_x     (o_new_x),
    .o_new_y     (o_new_y),
    .o_new_z_re  (o_new_z_re),
    .o_new_z_im  (o_new_z_im),
    .o_last_out  (o_last_out)
);

`default_nettype wire
